/* rtl/core/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms; each module that uses them provides clk and rst.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression never holds.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

/* rtl/core/gn2d_pkg.sv */
// -----------------------------------------------------------------------------
// Gradient noise package
// Widths, codes and the operation record passed from front end to back end.
// -----------------------------------------------------------------------------
package gn2d_pkg;

  localparam int GRID_SIDE_DEF = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int COORD_W   = 16;
  localparam int ADDR_W    = 16;
  localparam int GRAD_W    = 16;
  localparam int ENTRY_W   = 2 * GRAD_W;
  localparam int NOISE_W   = 16;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int OPQ_DEPTH  = 4;
  localparam int RESQ_DEPTH = 4;

  // Corner slots: column low/high, row low/high
  localparam int CORNER_00 = 0;
  localparam int CORNER_10 = 1;
  localparam int CORNER_01 = 2;
  localparam int CORNER_11 = 3;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_EVAL  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic [ADDR_W-1:0]            table_index;
    logic [GRAD_W-1:0]            grad_x;
    logic [GRAD_W-1:0]            grad_y;
    logic [COORD_W-1:0]           frac_x;
    logic [COORD_W-1:0]           frac_y;
    logic [3:0][ADDR_W-1:0]       corner_addr;
  } op_t;

endpackage

/* rtl/core/gradient_noise_2d_top.sv */
// -----------------------------------------------------------------------------
// 2D gradient noise
// Loads a gradient table and evaluates blended corner dot products at points.
// -----------------------------------------------------------------------------
//
//   Channel   Handshake          Fields
//   --------  -----------------  -------------------------------------------
//   input     push / full        kind, table_index, grad_x, grad_y,
//                                point_x, point_y
//   result    pop / empty        noise_value (evaluate items only)
//
// One item per cycle sustained unless a queue stalls: the front end (5 stages)
// computes wrapped corner addresses, the back end (10 stages) reads all four
// corners together from two copies of the gradient store, each with two read
// ports. An evaluate item's result reaches the result ports through the
// operation queue, the back end and the result queue; stalls delay it.
// Reset clears valid bits, queue counts and queue pointers only; the store
// holds nothing defined until each entry is written. full rises when the
// operation queue is full and the front end output is held; the back end
// stalls when the result queue is full.
// -----------------------------------------------------------------------------

module gradient_noise_2d_top #(
  parameter int GRID_SIDE = gn2d_pkg::GRID_SIDE_DEF,
  parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                kind,
  input  logic [gn2d_pkg::ADDR_W-1:0]         table_index,
  input  logic [gn2d_pkg::GRAD_W-1:0]         grad_x,
  input  logic [gn2d_pkg::GRAD_W-1:0]         grad_y,
  input  logic [gn2d_pkg::COORD_W-1:0]        point_x,
  input  logic [gn2d_pkg::COORD_W-1:0]        point_y,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [gn2d_pkg::NOISE_W-1:0] noise_value
);
  import gn2d_pkg::*;

  localparam int OP_W = $bits(op_t);

  // front end -> operation queue
  logic              fe_valid;
  op_t               fe_op;
  logic              opq_full;

  // operation queue -> back end
  logic              opq_empty;
  logic [OP_W-1:0]   opq_dout;
  op_t               be_op;
  logic              be_pop;

  // back end -> result queue
  logic              be_push;
  logic              resq_full;
  logic signed [NOISE_W-1:0] be_value;
  logic [NOISE_W-1:0]        resq_dout;

  assign be_op       = op_t'(opq_dout);
  assign noise_value = signed'(resq_dout);

  // Decode the item and compute the four corner addresses
  gn2d_front #(
    .GRID_SIDE (GRID_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .table_index (table_index),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .point_x     (point_x),
    .point_y     (point_y),
    .op_valid    (fe_valid),
    .op          (fe_op),
    .op_full     (opq_full)
  );

  // Decouple front and back so each can stall on its own
  gn2d_fifo #(
    .WIDTH (OP_W),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_valid),
    .full  (opq_full),
    .din   (fe_op),
    .pop   (be_pop),
    .empty (opq_empty),
    .dout  (opq_dout)
  );

  // Write the store or evaluate the point
  gn2d_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_empty  (opq_empty),
    .op        (be_op),
    .op_pop    (be_pop),
    .res_full  (resq_full),
    .res_push  (be_push),
    .res_value (be_value)
  );

  // Hold finished results until the consumer pops them
  gn2d_fifo #(
    .WIDTH (NOISE_W),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (be_push),
    .full  (resq_full),
    .din   (be_value),
    .pop   (pop),
    .empty (empty),
    .dout  (resq_dout)
  );

endmodule

/* rtl/core/gn2d_fifo.sv */
// -----------------------------------------------------------------------------
// Small FIFO
// Register-based queue with push/full and pop/empty handshakes.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module gn2d_fifo #(
  parameter int WIDTH = gn2d_pkg::NOISE_W,
  parameter int DEPTH = gn2d_pkg::RESQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);
  import gn2d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= din;
    end
  end

  `ASSERT_CLK(a_fifo_inc, (push_ok && !pop_ok) |=> (count == CNT_W'($past(count)) + CNT_W'(1)), "fifo count did not grow on push")
  `ASSERT_CLK(a_fifo_dec, (pop_ok && !push_ok) |=> (count == CNT_W'($past(count)) - CNT_W'(1)), "fifo count did not shrink on pop")
  `ASSERT_NEVER(a_fifo_range, count > CNT_W'(DEPTH), "fifo count beyond depth")

endmodule

/* rtl/core/gn2d_front.sv */
// -----------------------------------------------------------------------------
// Gradient noise front end
// Accepts items and works out the four wrapped corner addresses of a point.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module gn2d_front #(
  parameter int GRID_SIDE = gn2d_pkg::GRID_SIDE_DEF,
  parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind,
  input  logic [gn2d_pkg::ADDR_W-1:0]  table_index,
  input  logic [gn2d_pkg::GRAD_W-1:0]  grad_x,
  input  logic [gn2d_pkg::GRAD_W-1:0]  grad_y,
  input  logic [gn2d_pkg::COORD_W-1:0] point_x,
  input  logic [gn2d_pkg::COORD_W-1:0] point_y,
  output logic                         op_valid,
  output gn2d_pkg::op_t                op,
  input  logic                         op_full
);
  import gn2d_pkg::*;

  localparam int IPW  = (COORD_W > FRAC_BITS) ? COORD_W - FRAC_BITS : 1;
  localparam int CW   = $clog2(GRID_SIDE);
  localparam int SH   = IPW + CW;
  localparam int RW   = IPW + 1;
  localparam int PW   = IPW + RW;
  localparam int QGW  = IPW + CW + 1;
  localparam int AWW  = 2 * CW + 2;
  localparam int NSTG = 5;
  localparam int AX_X = 0;
  localparam int AX_Y = 1;

  // floor(2^SH / side): quotient estimate is low by at most one
  localparam logic [RW-1:0]      RECIP    = RW'((64'd1 << SH) / GRID_SIDE);
  localparam logic [COORD_W-1:0] FMASK    = COORD_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [CW:0]        SIDE     = (CW + 1)'(GRID_SIDE);
  localparam logic [CW-1:0]      LAST_IDX = CW'(GRID_SIDE - 1);

  logic [NSTG-1:0]          vld;
  logic                     adv;
  op_t                      st_op [NSTG];
  op_t                      op_in;
  op_t                      op_addr;

  logic [1:0][COORD_W-1:0]  pt;
  logic [1:0][COORD_W-1:0]  shifted;
  logic [1:0][IPW-1:0]      ip_in;
  logic [1:0][IPW-1:0]      ip0;
  logic [1:0][IPW-1:0]      ip1;
  logic [1:0][PW-1:0]       prod_in;
  logic [1:0][PW-1:0]       prod;
  logic [1:0][QGW-1:0]      qg_in;
  logic [1:0][QGW-1:0]      qg;
  logic [1:0][CW:0]         rr_in;
  logic [1:0][CW:0]         rr;
  logic [1:0][CW-1:0]       lo_in;
  logic [1:0][CW-1:0]       hi_in;
  logic [1:0][CW-1:0]       lo;
  logic [1:0][CW-1:0]       hi;
  logic [3:0][ADDR_W-1:0]   addr_in;

  assign adv      = !vld[NSTG-1] || !op_full;
  assign full     = !adv;
  assign op_valid = vld[NSTG-1];
  assign op       = st_op[NSTG-1];

  always_comb begin
    pt[AX_X] = point_x;
    pt[AX_Y] = point_y;

    op_in             = '0;
    op_in.kind        = kind_t'(kind);
    op_in.table_index = table_index;
    op_in.grad_x      = grad_x;
    op_in.grad_y      = grad_y;
    op_in.frac_x      = point_x & FMASK;
    op_in.frac_y      = point_y & FMASK;

    for (int a = 0; a < 2; a++) begin
      shifted[a] = pt[a] >> FRAC_BITS;
      ip_in[a]   = shifted[a][IPW-1:0];
      prod_in[a] = PW'(ip_in[a]) * PW'(RECIP);
      qg_in[a]   = QGW'(prod[a] >> SH) * QGW'(SIDE);
      rr_in[a]   = (CW + 1)'(QGW'(ip1[a]) - qg[a]);
      lo_in[a]   = (rr[a] >= SIDE) ? CW'(rr[a] - SIDE) : rr[a][CW-1:0];
      hi_in[a]   = (lo_in[a] == LAST_IDX) ? '0 : lo_in[a] + CW'(1);
    end

    addr_in[CORNER_00] = ADDR_W'(AWW'(lo[AX_Y]) * AWW'(SIDE) + AWW'(lo[AX_X]));
    addr_in[CORNER_10] = ADDR_W'(AWW'(lo[AX_Y]) * AWW'(SIDE) + AWW'(hi[AX_X]));
    addr_in[CORNER_01] = ADDR_W'(AWW'(hi[AX_Y]) * AWW'(SIDE) + AWW'(lo[AX_X]));
    addr_in[CORNER_11] = ADDR_W'(AWW'(hi[AX_Y]) * AWW'(SIDE) + AWW'(hi[AX_X]));

    op_addr             = st_op[3];
    op_addr.corner_addr = addr_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], push};
    end
  end

  // Stages: reciprocal multiply, quotient times side, remainder,
  // wrap and neighbor, corner address.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_op[0] <= op_in;
      prod     <= prod_in;
      ip0      <= ip_in;
      st_op[1] <= st_op[0];
      qg       <= qg_in;
      ip1      <= ip0;
      st_op[2] <= st_op[1];
      rr       <= rr_in;
      st_op[3] <= st_op[2];
      lo       <= lo_in;
      hi       <= hi_in;
      st_op[4] <= op_addr;
    end
  end

  `ASSERT_CLK(a_front_hold, (op_valid && op_full) |=> (op_valid && $stable(op)), "front end lost a held item")

endmodule

/* rtl/core/gn2d_back.sv */
// -----------------------------------------------------------------------------
// Gradient noise back end
// Gradient store, corner dot products, x and y blends, rounding and saturation.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module gn2d_back #(
  parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                op_empty,
  input  gn2d_pkg::op_t                       op,
  output logic                                op_pop,
  input  logic                                res_full,
  output logic                                res_push,
  output logic signed [gn2d_pkg::NOISE_W-1:0] res_value
);
  import gn2d_pkg::*;

  localparam int OW  = FRAC_BITS + 1;
  localparam int GW  = GRAD_W + 1;
  localparam int DW  = OW + GW;
  localparam int DFW = DW + 1;
  localparam int BPW = DFW + OW;

  localparam int S_MEM  = 0;
  localparam int S_MUL  = 1;
  localparam int S_DOT  = 2;
  localparam int S_XD   = 3;
  localparam int S_XM   = 4;
  localparam int S_XS   = 5;
  localparam int S_YD   = 6;
  localparam int S_YM   = 7;
  localparam int S_YS   = 8;
  localparam int S_OUT  = 9;
  localparam int NSTG   = S_OUT + 1;
  localparam int FRAC_N = S_YD + 1;

  localparam logic signed [DFW-1:0] ROUND_ONE = DFW'(64'd1 << FRAC_BITS);
  localparam logic signed [DFW-1:0] SAT_MAX   = DFW'((64'd1 << (NOISE_W - 1)) - 64'd1);
  localparam logic signed [DFW-1:0] SAT_MIN   = ~SAT_MAX;

  logic [NSTG-1:0]             vld;
  logic                        adv;
  logic                        wr_en;

  logic [ENTRY_W-1:0]          mem_top [MEM_DEPTH];
  logic [ENTRY_W-1:0]          mem_bot [MEM_DEPTH];
  logic [3:0][ENTRY_W-1:0]     rd;
  logic [2*FRAC_BITS-1:0]      frac_sr [FRAC_N];

  logic signed [OW-1:0]        ox [4];
  logic signed [OW-1:0]        oy [4];
  logic signed [GW-1:0]        gx [4];
  logic signed [GW-1:0]        gy [4];
  logic signed [DW-1:0]        px_in [4];
  logic signed [DW-1:0]        py_in [4];
  logic signed [DW-1:0]        px [4];
  logic signed [DW-1:0]        py [4];
  logic signed [DW-1:0]        dot [4];

  logic signed [OW-1:0]        wx;
  logic signed [OW-1:0]        wy;
  logic signed [DFW-1:0]       dtop;
  logic signed [DFW-1:0]       dbot;
  logic signed [DW-1:0]        atop_xd;
  logic signed [DW-1:0]        abot_xd;
  logic signed [BPW-1:0]       mtop_in;
  logic signed [BPW-1:0]       mbot_in;
  logic signed [BPW-1:0]       mtop;
  logic signed [BPW-1:0]       mbot;
  logic signed [DW-1:0]        atop_xm;
  logic signed [DW-1:0]        abot_xm;
  logic signed [DW-1:0]        top_in;
  logic signed [DW-1:0]        bot_in;
  logic signed [DW-1:0]        top_xs;
  logic signed [DW-1:0]        bot_xs;
  logic signed [DFW-1:0]       dy_in;
  logic signed [DFW-1:0]       dy;
  logic signed [DW-1:0]        top_yd;
  logic signed [BPW-1:0]       my_in;
  logic signed [BPW-1:0]       my;
  logic signed [DW-1:0]        top_ym;
  logic signed [DW-1:0]        v_in;
  logic signed [DW-1:0]        v_ys;
  logic signed [DFW-1:0]       vr;
  logic signed [DFW-1:0]       qv;
  logic signed [NOISE_W-1:0]   res_in;

  assign adv      = !vld[S_OUT] || !res_full;
  assign op_pop   = adv && !op_empty;
  assign wr_en    = op_pop && (op.kind == KIND_WRITE);
  assign res_push = vld[S_OUT];

  // Two copies of the store, each read at two corners per cycle while not stalled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_top[op.table_index] <= {op.grad_y, op.grad_x};
      mem_bot[op.table_index] <= {op.grad_y, op.grad_x};
    end
    if (adv) begin
      rd[CORNER_00] <= mem_top[op.corner_addr[CORNER_00]];
      rd[CORNER_10] <= mem_top[op.corner_addr[CORNER_10]];
      rd[CORNER_01] <= mem_bot[op.corner_addr[CORNER_01]];
      rd[CORNER_11] <= mem_bot[op.corner_addr[CORNER_11]];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      // high corner offset is frac - 1.0, i.e. the sign bit set over frac
      ox[c] = signed'({(c == CORNER_10) || (c == CORNER_11),
                       frac_sr[S_MEM][FRAC_BITS-1:0]});
      oy[c] = signed'({(c == CORNER_01) || (c == CORNER_11),
                       frac_sr[S_MEM][2*FRAC_BITS-1:FRAC_BITS]});
      gx[c]    = signed'({1'b0, rd[c][GRAD_W-1:0]});
      gy[c]    = signed'({1'b0, rd[c][ENTRY_W-1:GRAD_W]});
      px_in[c] = ox[c] * gx[c];
      py_in[c] = oy[c] * gy[c];
    end

    wx      = signed'({1'b0, frac_sr[S_XD][FRAC_BITS-1:0]});
    wy      = signed'({1'b0, frac_sr[S_YD][2*FRAC_BITS-1:FRAC_BITS]});
    mtop_in = dtop * wx;
    mbot_in = dbot * wx;
    top_in  = DW'(BPW'(atop_xm) + (mtop >>> FRAC_BITS));
    bot_in  = DW'(BPW'(abot_xm) + (mbot >>> FRAC_BITS));
    dy_in   = DFW'(bot_xs) - DFW'(top_xs);
    my_in   = dy * wy;
    v_in    = DW'(BPW'(top_ym) + (my >>> FRAC_BITS));

    vr = DFW'(v_ys) + ROUND_ONE;
    qv = vr >>> (FRAC_BITS + 1);
    if (qv > SAT_MAX) begin
      res_in = NOISE_W'(SAT_MAX);
    end else if (qv < SAT_MIN) begin
      res_in = NOISE_W'(SAT_MIN);
    end else begin
      res_in = NOISE_W'(qv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], !op_empty && (op.kind == KIND_EVAL)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frac_sr[0] <= {op.frac_y[FRAC_BITS-1:0], op.frac_x[FRAC_BITS-1:0]};
      for (int k = 1; k < FRAC_N; k++) begin
        frac_sr[k] <= frac_sr[k-1];
      end
      for (int c = 0; c < 4; c++) begin
        px[c]  <= px_in[c];
        py[c]  <= py_in[c];
        dot[c] <= px[c] + py[c];
      end
      dtop      <= DFW'(dot[CORNER_10]) - DFW'(dot[CORNER_00]);
      dbot      <= DFW'(dot[CORNER_11]) - DFW'(dot[CORNER_01]);
      atop_xd   <= dot[CORNER_00];
      abot_xd   <= dot[CORNER_01];
      mtop      <= mtop_in;
      mbot      <= mbot_in;
      atop_xm   <= atop_xd;
      abot_xm   <= abot_xd;
      top_xs    <= top_in;
      bot_xs    <= bot_in;
      dy        <= dy_in;
      top_yd    <= top_xs;
      my        <= my_in;
      top_ym    <= top_yd;
      v_ys      <= v_in;
      res_value <= res_in;
    end
  end

  `ASSERT_CLK(a_back_hold, (vld[S_OUT] && !adv) |=> (vld[S_OUT] && $stable(res_value)), "stalled result changed")
  `ASSERT_CLK(a_back_entry, op_pop |=> (vld[S_MEM] == ($past(op.kind) == KIND_EVAL)), "popped item entered the pipeline wrongly")

endmodule
